// ===== rtl/core/skf_pkg.sv =====
package skf_pkg;

  // Default values for the top-level parameters.
  localparam int CHANNELS_DEF  = 2;
  localparam int FRAC_BITS_DEF = 16;

  // Field widths.
  localparam int EST_W      = 32;
  localparam int COV_W      = 24;
  localparam int GAIN_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_Q0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Q1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_R0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_R1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd5;

  // Commands for the shared shift-add/subtract unit.
  typedef enum logic [1:0] {
    ALU_HOLD = 2'd0,
    ALU_LOAD = 2'd1,
    ALU_DIV  = 2'd2,
    ALU_MUL  = 2'd3
  } alu_op_t;

endpackage

// ===== rtl/core/skf_alu.sv =====
module skf_alu #(
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  skf_pkg::alu_op_t             op,
  input  logic signed [FRAC_BITS+35:0] acc_init,
  input  logic signed [FRAC_BITS+35:0] opnd_init,
  input  logic [FRAC_BITS:0]           bits_init,
  output logic signed [FRAC_BITS+35:0] acc,
  output logic [FRAC_BITS:0]           bits
);
  import skf_pkg::*;

  localparam int AW = FRAC_BITS + 36;
  localparam int KW = FRAC_BITS + 1;

  logic signed [AW-1:0] opnd;
  logic signed [AW-1:0] shifted;
  logic signed [AW-1:0] addend;
  logic signed [AW-1:0] sum;
  logic                 top_bit;

  // The bit register is consumed MSB first: numerator bits for a divide,
  // multiplier bits for a multiply.
  assign top_bit = bits[KW-1];

  // One adder serves both the restoring divide and the shift-add multiply.
  always_comb begin
    shifted = {acc[AW-2:0], (op == ALU_DIV) ? top_bit : 1'b0};
    addend  = '0;
    if (op == ALU_DIV) begin
      addend = -opnd;
    end else if (top_bit) begin
      addend = opnd;
    end
    sum = shifted + addend;
  end

  // Accumulator, operand and bit register; quotient bits shift in at the bottom.
  always_ff @(posedge clk) begin
    case (op)
      ALU_LOAD: begin
        acc  <= acc_init;
        opnd <= opnd_init;
        bits <= bits_init;
      end
      ALU_DIV: begin
        if (!sum[AW-1]) begin
          acc  <= sum;
          bits <= {bits[KW-2:0], 1'b1};
        end else begin
          acc  <= shifted;
          bits <= {bits[KW-2:0], 1'b0};
        end
      end
      ALU_MUL: begin
        acc  <= sum;
        bits <= {bits[KW-2:0], 1'b0};
      end
      default: begin
      end
    endcase
  end

  // During a divide the partial remainder always stays below the divisor.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (op == ALU_DIV) |-> (acc >= 0 && acc < opnd))
    else $error("divider remainder out of range");

endmodule

// ===== rtl/core/scalar_kalman_filter.sv =====
// Scalar Kalman filter with one estimate and one covariance per channel.
// Input beats arrive on the s_axis group: tdata carries the channel number
// and the signed Q15.16 measurement. For each input beat exactly one output
// beat leaves on the m_axis group with the new estimate and the gain used.
// Q, R and the drift bias of each channel are written through the cfg port,
// which is always ready; write it only while no update is in flight.
// One update runs the prediction, denominator, division, multiplier load,
// first multiplication, rounding, second multiplication and final steps in
// that order; when P + R is zero the division is skipped. The single
// shift-add/subtract unit runs the gain division and the two multiplications
// one bit per cycle.
// The block takes one input beat at a time; s_axis_tready is high only while
// it is idle. A finished result waits in the output register; the next update
// may run meanwhile and holds its final step until that register is free.
// Reset clears all configuration registers to zero, every estimate to zero
// and every covariance to 0.02, drops m_axis_tvalid and leaves the input
// side ready.
module scalar_kalman_filter #(
  parameter int CHANNELS  = skf_pkg::CHANNELS_DEF,
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Bit 0: channel; bits 32..1: measurement; bits 39..33: zero.
  input  logic [skf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Bits 31..0: estimate; bits 48..32: gain; bits 55..49: zero.
  output logic [skf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [skf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import skf_pkg::*;

  localparam int AW    = FRAC_BITS + 36;
  localparam int KW    = FRAC_BITS + 1;
  localparam int NW    = FRAC_BITS + 25;
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  localparam logic [COV_W-1:0] COV_MAX = '1;
  localparam longint unsigned P_INIT_RAW = ((64'd2 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [COV_W-1:0] P_INIT =
    (P_INIT_RAW > 64'(COV_MAX)) ? COV_MAX : P_INIT_RAW[COV_W-1:0];
  localparam logic [KW-1:0] ONE_K = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [AW-1:0] HALF =
    {{(AW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PRED = 9'b000000010,
    S_DEN  = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_LDM  = 9'b000010000,
    S_MUL1 = 9'b000100000,
    S_RND  = 9'b001000000,
    S_MUL2 = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state;
  logic [CNT_W-1:0] cnt;

  // Configuration registers.
  logic [COV_W-1:0]        q0, q1, r0, r1;
  logic signed [EST_W-1:0] b0, b1;

  // Per-channel filter state.
  logic signed [EST_W-1:0] est_store [CHANNELS];
  logic [COV_W-1:0]        cov_store [CHANNELS];

  // Working registers of the current update.
  logic [CW-1:0]           ch;
  logic signed [EST_W-1:0] z;
  logic [COV_W-1:0]        pn;
  logic signed [EST_W-1:0] xb;
  logic                    den_zero;
  logic [KW-1:0]           k;
  logic signed [35:0]      corr;

  // Output register.
  logic                    out_valid;
  logic signed [EST_W-1:0] est_out;
  logic [GAIN_W-1:0]       gain_out;

  // Shared unit interface.
  alu_op_t                 alu_op;
  logic signed [AW-1:0]    alu_acc_init, alu_opnd_init, alu_acc;
  logic [KW-1:0]           alu_bits_init, alu_bits;

  // Combinational values.
  logic [COV_W-1:0]        q_sel, r_sel;
  logic signed [EST_W-1:0] b_sel;
  logic [COV_W:0]          pn_sum, den_w;
  logic signed [EST_W:0]   xb_sum, diff;
  logic [NW-1:0]           num;
  logic [KW-1:0]           k_use;
  logic signed [AW-1:0]    rnd_sum;
  logic signed [35:0]      rnd_q;
  logic [COV_W-1:0]        p_new;
  logic signed [EST_W+4:0] xn_sum;
  logic signed [EST_W-1:0] x_new;
  logic                    out_free;
  logic                    in_beat;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-EST_W-GAIN_W){1'b0}}, gain_out, est_out};
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  // Register pair follows the low bit of the channel.
  assign q_sel = ch[0] ? q1 : q0;
  assign r_sel = ch[0] ? r1 : r0;
  assign b_sel = ch[0] ? b1 : b0;

  // Prediction, gain denominator and numerator, innovation, and final rounding and saturation.
  always_comb begin
    pn_sum  = {1'b0, cov_store[ch]} + {1'b0, q_sel};
    xb_sum  = {est_store[ch][EST_W-1], est_store[ch]} + {b_sel[EST_W-1], b_sel};
    den_w   = {1'b0, pn} + {1'b0, r_sel};
    num     = {1'b0, pn, {FRAC_BITS{1'b0}}} + NW'(den_w >> 1);
    k_use   = den_zero ? '0 : alu_bits;
    diff    = {z[EST_W-1], z} - {xb[EST_W-1], xb};
    rnd_sum = alu_acc + HALF;
    rnd_q   = rnd_sum[AW-1:FRAC_BITS];
    if (rnd_q[35:COV_W] != '0) begin
      p_new = COV_MAX;
    end else begin
      p_new = rnd_q[COV_W-1:0];
    end
    xn_sum = {xb[EST_W-1], xb[EST_W-1], xb[EST_W-1], xb[EST_W-1], xb[EST_W-1], xb}
           + {corr[35], corr};
    if (xn_sum[EST_W+4:EST_W-1] == '0 || xn_sum[EST_W+4:EST_W-1] == '1) begin
      x_new = xn_sum[EST_W-1:0];
    end else if (xn_sum[EST_W+4]) begin
      x_new = {1'b1, {(EST_W-1){1'b0}}};
    end else begin
      x_new = {1'b0, {(EST_W-1){1'b1}}};
    end
  end

  // Commands to the shared unit for each step of the sequence.
  always_comb begin
    alu_op        = ALU_HOLD;
    alu_acc_init  = '0;
    alu_opnd_init = '0;
    alu_bits_init = '0;
    case (state)
      S_DEN: begin
        alu_op        = ALU_LOAD;
        alu_acc_init  = AW'(num >> KW);
        alu_opnd_init = AW'(den_w);
        alu_bits_init = num[KW-1:0];
      end
      S_DIV: begin
        alu_op = ALU_DIV;
      end
      S_LDM: begin
        alu_op        = ALU_LOAD;
        alu_opnd_init = AW'(diff);
        alu_bits_init = k_use;
      end
      S_MUL1, S_MUL2: begin
        alu_op = ALU_MUL;
      end
      S_RND: begin
        alu_op        = ALU_LOAD;
        alu_opnd_init = AW'(pn);
        alu_bits_init = ONE_K - k;
      end
      default: begin
        alu_op = ALU_HOLD;
      end
    endcase
  end

  skf_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk      (clk),
    .rst      (rst),
    .op       (alu_op),
    .acc_init (alu_acc_init),
    .opnd_init(alu_opnd_init),
    .bits_init(alu_bits_init),
    .acc      (alu_acc),
    .bits     (alu_bits)
  );

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      q0 <= '0;
      q1 <= '0;
      r0 <= '0;
      r1 <= '0;
      b0 <= '0;
      b1 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_Q0:  q0 <= cfg_data[COV_W-1:0];
        REG_Q1:  q1 <= cfg_data[COV_W-1:0];
        REG_R0:  r0 <= cfg_data[COV_W-1:0];
        REG_R1:  r1 <= cfg_data[COV_W-1:0];
        REG_B0:  b0 <= cfg_data;
        REG_B1:  b1 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer, filter state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        est_store[i] <= '0;
        cov_store[i] <= P_INIT;
      end
    end else begin
      // The final step refills the output register itself.
      if (out_valid && m_axis_tready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            state <= S_PRED;
          end
        end
        S_PRED: begin
          state <= S_DEN;
        end
        S_DEN: begin
          cnt   <= CNT_W'(FRAC_BITS);
          state <= (den_w == '0) ? S_LDM : S_DIV;
        end
        S_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_LDM;
          end
        end
        S_LDM: begin
          cnt   <= CNT_W'(FRAC_BITS);
          state <= S_MUL1;
        end
        S_MUL1: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_RND;
          end
        end
        S_RND: begin
          cnt   <= CNT_W'(FRAC_BITS);
          state <= S_MUL2;
        end
        S_MUL2: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            est_store[ch] <= x_new;
            cov_store[ch] <= p_new;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working and output registers.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      ch <= (CHANNELS > 1) ? CW'(s_axis_tdata[0]) : '0;
      z  <= s_axis_tdata[EST_W:1];
    end
    if (state == S_PRED) begin
      pn <= pn_sum[COV_W] ? COV_MAX : pn_sum[COV_W-1:0];
      if (xb_sum[EST_W] == xb_sum[EST_W-1]) begin
        xb <= xb_sum[EST_W-1:0];
      end else if (xb_sum[EST_W]) begin
        xb <= {1'b1, {(EST_W-1){1'b0}}};
      end else begin
        xb <= {1'b0, {(EST_W-1){1'b1}}};
      end
    end
    if (state == S_DEN) begin
      den_zero <= (den_w == '0);
    end
    if (state == S_LDM) begin
      k <= k_use;
    end
    if (state == S_RND) begin
      corr <= rnd_q;
    end
    if (state == S_FIN && out_free) begin
      est_out  <= x_new;
      gain_out <= GAIN_W'(k);
    end
  end

  // An accepted beat always starts the prediction step next.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> (state == S_PRED))
    else $error("accepted beat did not start an update");

  // The quotient from the divider never exceeds a gain of one.
  a_gain_le_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_LDM && !den_zero) |-> (alu_bits <= ONE_K))
    else $error("gain above one");

  // A finished update waits while the previous result is still held.
  a_fin_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !m_axis_tready) |=> (state == S_FIN && out_valid))
    else $error("result register overwritten");

endmodule
